// ===== rtl/lpd_pkg.sv =====
// Shared types and constants of the length-prefix deframer.
`default_nettype none

package lpd_pkg;

    // Command codes carried with each input transaction.
    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_CLOSE   = 2'd2
    } t_cmd;

    // Frame kinds reported on the frame-end transaction.
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_HELLO = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    localparam int unsigned LEN_W   = 32;
    localparam int unsigned MATCH_W = 3;

    localparam logic [MATCH_W-1:0] HELLO_LEN = 3'd5;
    localparam logic [MATCH_W-1:0] END_LEN   = 3'd3;
    localparam logic [MATCH_W-1:0] MATCH_SAT = 3'd7;

    localparam logic [7:0] HELLO_TEXT [5] = '{8'h48, 8'h45, 8'h4C, 8'h4C, 8'h4F};
    localparam logic [7:0] END_TEXT   [3] = '{8'h45, 8'h4E, 8'h44};

endpackage

`default_nettype wire

// ===== rtl/lpd_if.sv =====
// Handshake interfaces for the deframer input and result channels.
`default_nettype none

interface lpd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] in_byte;

    modport source (output valid, output cmd, output in_byte, input ready);
    modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface lpd_out_if;
    logic        valid;
    logic        ready;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [1:0]  frame_kind;
    logic [31:0] frame_length;

    modport source (output valid, output data_valid, output data_byte, output frame_end,
                    output frame_kind, output frame_length, input ready);
    modport sink   (input valid, input data_valid, input data_byte, input frame_end,
                    input frame_kind, input frame_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/length_prefix_deframer_core.sv =====
// Top level of the length-prefix deframer: header parser, payload pass-through, frame tagger.
`default_nettype none

// Channel   Direction  Transaction contents
// i_in      sink       cmd (byte, restart, close) and one received byte
// o_out     source     payload byte and/or frame end with kind and length
//
// An accepted transaction lands in an input register; once the result register can take
// a new one, the parser runs on it against the frame state and writes the result register.
// One transaction per cycle is sustained while the result register is not held by a stall;
// a pass that emits loads the result register, which drives o_out directly.
// The input register advances whenever the result register is empty or being drained,
// so i_in.ready drops only while both the input and result registers are held.
// Reset (synchronous, active low) clears both valid flags and all parser state.

module length_prefix_deframer_core #(
    parameter int unsigned HEADER_BYTES = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lpd_in_if.sink     i_in,
    lpd_out_if.source  o_out
);
    import lpd_pkg::*;

    localparam int unsigned HC_W = $clog2(HEADER_BYTES + 1);
    localparam logic [HC_W-1:0] HDR_LAST = HC_W'(HEADER_BYTES);

    // Input register. Payload needs no reset.
    logic             r_in_valid;
    logic [1:0]       r_cmd;
    logic [7:0]       r_byte;

    // Parser state.
    logic [HC_W-1:0]    r_hdr_count,  n_hdr_count;
    logic [LEN_W-1:0]   r_len_shift,  n_len_shift;
    logic [LEN_W-1:0]   r_remaining,  n_remaining;
    logic [MATCH_W-1:0] r_match_pos,  n_match_pos;
    logic               r_hello_match, n_hello_match;
    logic               r_end_match,   n_end_match;
    logic               r_hello_seen,  n_hello_seen;
    logic               r_closed,      n_closed;

    // Result register.
    logic             r_out_valid;
    logic             r_data_valid, n_data_valid;
    logic [7:0]       r_data_byte,  n_data_byte;
    logic             r_frame_end,  n_frame_end;
    t_kind            r_frame_kind, n_frame_kind;
    logic [LEN_W-1:0] r_frame_len,  n_frame_len;
    logic             n_emit;

    logic adv;

    // The held transaction is processed when the result register can take a new one.
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd  <= i_in.cmd;
            r_byte <= i_in.in_byte;
        end
    end

    // Parser: one transaction per pass, producing at most one result.
    always_comb begin
        logic [LEN_W-1:0]   shift_in;
        logic [HC_W-1:0]    hc_inc;
        logic               hm;
        logic               em;

        n_hdr_count   = r_hdr_count;
        n_len_shift   = r_len_shift;
        n_remaining   = r_remaining;
        n_match_pos   = r_match_pos;
        n_hello_match = r_hello_match;
        n_end_match   = r_end_match;
        n_hello_seen  = r_hello_seen;
        n_closed      = r_closed;
        n_emit        = 1'b0;
        n_data_valid  = 1'b0;
        n_data_byte   = 8'd0;
        n_frame_end   = 1'b0;
        n_frame_kind  = KIND_DATA;
        n_frame_len   = '0;

        // A new frame starts its length from zero.
        shift_in = (r_hdr_count == '0) ? {(LEN_W-8)'(0), r_byte}
                                       : {r_len_shift[LEN_W-9:0], r_byte};
        hc_inc   = r_hdr_count + 1'b1;

        // Running match of the payload against the two keywords.
        hm = r_hello_match;
        if (r_match_pos < HELLO_LEN) begin
            if (HELLO_TEXT[r_match_pos] != r_byte) begin
                hm = 1'b0;
            end
        end else begin
            hm = 1'b0;
        end
        em = r_end_match;
        if (r_match_pos < END_LEN) begin
            if (END_TEXT[r_match_pos[1:0]] != r_byte) begin
                em = 1'b0;
            end
        end else begin
            em = 1'b0;
        end

        case (t_cmd'(r_cmd))
            CMD_RESTART: begin
                n_hello_seen = 1'b0;
                n_closed     = 1'b0;
            end
            CMD_CLOSE: begin
                n_closed = 1'b1;
            end
            CMD_BYTE: begin
                if (!r_closed) begin
                    if (r_hdr_count < HDR_LAST) begin
                        n_len_shift = shift_in;
                        n_hdr_count = hc_inc;
                        if (hc_inc == HDR_LAST) begin
                            n_remaining   = shift_in;
                            n_match_pos   = '0;
                            n_hello_match = 1'b1;
                            n_end_match   = 1'b1;
                            // An empty frame ends right on its last header byte.
                            if (shift_in == '0) begin
                                n_hdr_count = '0;
                                n_emit      = 1'b1;
                                n_frame_end = 1'b1;
                            end
                        end
                    end else begin
                        n_hello_match = hm;
                        n_end_match   = em;
                        if (r_match_pos < MATCH_SAT) begin
                            n_match_pos = r_match_pos + 1'b1;
                        end
                        n_remaining  = r_remaining - 1'b1;
                        n_emit       = 1'b1;
                        n_data_valid = 1'b1;
                        n_data_byte  = r_byte;
                        if (r_remaining == LEN_W'(1)) begin
                            n_hdr_count = '0;
                            n_frame_end = 1'b1;
                            n_frame_len = r_len_shift;
                            // Only the first HELLO of a session is tagged as such.
                            if (!r_hello_seen && hm && r_len_shift == LEN_W'(HELLO_LEN)) begin
                                n_hello_seen = 1'b1;
                                n_frame_kind = KIND_HELLO;
                            end else if (em && r_len_shift == LEN_W'(END_LEN)) begin
                                n_frame_kind = KIND_END;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_count   <= '0;
            r_len_shift   <= '0;
            r_remaining   <= '0;
            r_match_pos   <= '0;
            r_hello_match <= 1'b0;
            r_end_match   <= 1'b0;
            r_hello_seen  <= 1'b0;
            r_closed      <= 1'b0;
        end else if (adv) begin
            r_hdr_count   <= n_hdr_count;
            r_len_shift   <= n_len_shift;
            r_remaining   <= n_remaining;
            r_match_pos   <= n_match_pos;
            r_hello_match <= n_hello_match;
            r_end_match   <= n_end_match;
            r_hello_seen  <= n_hello_seen;
            r_closed      <= n_closed;
        end
    end

    // Result register: loaded by a pass that emits, emptied when taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && n_emit) begin
            r_data_valid <= n_data_valid;
            r_data_byte  <= n_data_byte;
            r_frame_end  <= n_frame_end;
            r_frame_kind <= n_frame_kind;
            r_frame_len  <= n_frame_len;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.data_valid   = r_data_valid;
    assign o_out.data_byte    = r_data_byte;
    assign o_out.frame_end    = r_frame_end;
    assign o_out.frame_kind   = r_frame_kind;
    assign o_out.frame_length = r_frame_len;

`ifndef ASSERT_OFF
    a_hdr_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_count <= HDR_LAST)
        else $error("header count beyond header size");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_cmd) && $stable(r_byte))
        else $error("input register lost a held transaction");

    a_mid_frame_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.frame_end |-> o_out.data_valid)
        else $error("result without data or frame end");

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_end && !o_out.data_valid |->
            o_out.frame_length == '0 && o_out.frame_kind == KIND_DATA)
        else $error("empty frame result carries length or kind");

    a_hello_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_end && o_out.frame_kind == KIND_HELLO |->
            o_out.frame_length == LEN_W'(HELLO_LEN) && r_hello_seen)
        else $error("hello frame with wrong length or flag clear");
`endif

endmodule

`default_nettype wire

// ===== sim/lpd_deframer_checker.sv =====
// Checker for the length-prefix deframer: predicts each result and compares it on the output channel.
`default_nettype none

module lpd_deframer_checker #(
    parameter int unsigned HDR_BYTES = 4
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    lpd_in_if    in_mon,
    lpd_out_if   out_mon,
    output int   o_errors,
    output int   o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        frame_end;
        t_kind       frame_kind;
        logic [31:0] frame_length;
    } t_frame_out;

    t_frame_out expected_out[$];
    int         fail_cnt = 0;

    // Parser state as the block should hold it.
    logic [2:0]  hdr_cnt;
    logic [31:0] len_sr;
    logic [31:0] bytes_left;
    logic [2:0]  match_cnt;
    logic        hello_ok;
    logic        end_ok;
    logic        hello_seen;
    logic        stream_closed;

    assign o_errors  = fail_cnt;
    assign o_pending = expected_out.size();

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    // Runs one accepted transaction through the parser and says whether it
    // produces a result, and which.
    function automatic void deframe_step(input logic [1:0] cmd, input logic [7:0] b,
                                         output bit produced, output t_frame_out res);
        res      = '0;
        produced = 1'b0;
        case (cmd)
            CMD_RESTART: begin
                hello_seen    = 1'b0;
                stream_closed = 1'b0;
            end
            CMD_CLOSE: stream_closed = 1'b1;
            CMD_BYTE: begin
                if (!stream_closed) begin
                    if (hdr_cnt < HDR_BYTES) begin
                        if (hdr_cnt == 0) len_sr = '0;
                        len_sr  = {len_sr[23:0], b};
                        hdr_cnt = hdr_cnt + 3'd1;
                        if (hdr_cnt == HDR_BYTES) begin
                            bytes_left = len_sr;
                            match_cnt  = '0;
                            hello_ok   = 1'b1;
                            end_ok     = 1'b1;
                            if (len_sr == 0) begin
                                // An empty frame closes on its last header byte.
                                hdr_cnt          = '0;
                                produced         = 1'b1;
                                res.frame_end    = 1'b1;
                                res.frame_kind   = KIND_DATA;
                            end
                        end
                    end else begin
                        if (match_cnt < HELLO_LEN) begin
                            if (HELLO_TEXT[match_cnt] != b) hello_ok = 1'b0;
                        end else begin
                            hello_ok = 1'b0;
                        end
                        if (match_cnt < END_LEN) begin
                            if (END_TEXT[match_cnt[1:0]] != b) end_ok = 1'b0;
                        end else begin
                            end_ok = 1'b0;
                        end
                        if (match_cnt != MATCH_SAT) match_cnt = match_cnt + 3'd1;
                        bytes_left     = bytes_left - 32'd1;
                        produced       = 1'b1;
                        res.data_valid = 1'b1;
                        res.data_byte  = b;
                        if (bytes_left == 0) begin
                            hdr_cnt          = '0;
                            res.frame_end    = 1'b1;
                            res.frame_length = len_sr;
                            if (!hello_seen && hello_ok && len_sr == 32'(HELLO_LEN)) begin
                                hello_seen     = 1'b1;
                                res.frame_kind = KIND_HELLO;
                            end else if (end_ok && len_sr == 32'(END_LEN)) begin
                                res.frame_kind = KIND_END;
                            end else begin
                                res.frame_kind = KIND_DATA;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_frame_out want;
        t_frame_out next_res;
        bit         has_res;
        if (!i_rst_n) begin
            hdr_cnt       = '0;
            len_sr        = '0;
            bytes_left    = '0;
            match_cnt     = '0;
            hello_ok      = 1'b0;
            end_ok        = 1'b0;
            hello_seen    = 1'b0;
            stream_closed = 1'b0;
            expected_out.delete();
        end else begin
            // Results are compared before this edge's input is predicted, so a
            // spurious result can never pair with an expectation made just now.
            if (out_mon.valid && out_mon.ready) begin
                if (expected_out.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected (byte %0h)",
                                              out_mon.data_byte));
                end else begin
                    want = expected_out.pop_front();
                    if (out_mon.data_valid !== want.data_valid)
                        report_mismatch($sformatf("data_valid got %b expected %b",
                                                  out_mon.data_valid, want.data_valid));
                    if (out_mon.data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte got %0h expected %0h",
                                                  out_mon.data_byte, want.data_byte));
                    if (out_mon.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %b expected %b",
                                                  out_mon.frame_end, want.frame_end));
                    if (out_mon.frame_kind !== want.frame_kind)
                        report_mismatch($sformatf("frame_kind got %0d expected %0d",
                                                  out_mon.frame_kind, want.frame_kind));
                    if (out_mon.frame_length !== want.frame_length)
                        report_mismatch($sformatf("frame_length got %0h expected %0h",
                                                  out_mon.frame_length, want.frame_length));
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                deframe_step(in_mon.cmd, in_mon.in_byte, has_res, next_res);
                if (has_res) expected_out.insert(expected_out.size(), next_res);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/length_prefix_deframer_core_tb.sv =====
// Testbench top for the length-prefix deframer: stimulus, handshake idling, watchdog and verdict.
`default_nettype none

module length_prefix_deframer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    // The command field has one code the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET    = 1950;
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to keep watching once nothing is expected: covers the input and result
    // registers plus the longest receiver stall with a wide margin.
    localparam int DRAIN_CYCLES   = 40;

    logic i_clk;
    logic i_rst_n;

    lpd_in_if  in_ch ();
    lpd_out_if out_ch ();

    int errors;
    int pending;

    // Count of transactions that the parser acts on; bytes sent while the
    // stream is closed and the unused command are not counted.
    int   items_sent;
    bit   gen_closed;
    // While set, both sides run without idling.
    bit   no_idle;
    int   idle_cycles = 0;
    logic [7:0] payload[$];

    length_prefix_deframer_core #(
        .HEADER_BYTES (4)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lpd_deframer_checker #(
        .HDR_BYTES (4)
    ) chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sends one transaction after a random gap and returns once it has been
    // accepted. Valid is only lowered when a gap is drawn, so back-to-back
    // transactions keep it high without a glitch in the same time step.
    task automatic send(input logic [1:0] cmd, input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.in_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (cmd == CMD_RESTART || cmd == CMD_CLOSE || (cmd == CMD_BYTE && !gen_closed))
            items_sent++;
        if (cmd == CMD_RESTART) gen_closed = 1'b0;
        if (cmd == CMD_CLOSE) gen_closed = 1'b1;
    endtask

    // A detour that must leave the parser position alone: a restart, a close
    // with ignored traffic and a restart after it, or the unused command.
    task automatic side_trip();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            send(CMD_RESTART, 8'($urandom));
        end else if (pick == 1) begin
            send(CMD_CLOSE, 8'($urandom));
            repeat ($urandom_range(1, 4))
                send($urandom_range(0, 1) ? CMD_UNUSED : CMD_BYTE, 8'($urandom));
            send(CMD_RESTART, 8'($urandom));
        end else begin
            send(CMD_UNUSED, 8'($urandom));
        end
    endtask

    // Sends a big-endian length header and the payload held in the queue.
    // With interrupt set, a side trip lands at a random point in the frame,
    // header included.
    task automatic send_frame(input bit interrupt);
        int          len;
        int          cut;
        logic [31:0] hdr;
        len = payload.size();
        hdr = len;
        cut = interrupt ? $urandom_range(0, 3 + len) : -1;
        for (int k = 0; k < 4 + len; k++) begin
            if (k == cut) side_trip();
            if (k < 4) send(CMD_BYTE, hdr[31 - 8 * k -: 8]);
            else send(CMD_BYTE, payload[k - 4]);
        end
    endtask

    // Chooses a payload: the hello and end keywords, near misses of them,
    // keywords with trailing bytes, and random data of mostly short lengths.
    task automatic build_payload();
        int pick;
        int n;
        int r;
        payload.delete();
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1: for (int i = 0; i < 5; i++) payload.insert(payload.size(), HELLO_TEXT[i]);
            2, 3: for (int i = 0; i < 3; i++) payload.insert(payload.size(), END_TEXT[i]);
            4: begin
                // Longer than the keyword, so the match counter runs past it
                // and may saturate.
                if ($urandom_range(0, 1)) begin
                    for (int i = 0; i < 5; i++) payload.insert(payload.size(), HELLO_TEXT[i]);
                end else begin
                    for (int i = 0; i < 3; i++) payload.insert(payload.size(), END_TEXT[i]);
                end
                repeat ($urandom_range(1, 6)) payload.insert(payload.size(), 8'($urandom));
            end
            5: begin
                if ($urandom_range(0, 1)) begin
                    for (int i = 0; i < 5; i++) payload.insert(payload.size(), HELLO_TEXT[i]);
                end else begin
                    for (int i = 0; i < 3; i++) payload.insert(payload.size(), END_TEXT[i]);
                end
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    n = $urandom_range(0, payload.size() - 1);
                    payload[n] = payload[n] ^ 8'($urandom_range(1, 255));
                end else if (r == 1) begin
                    void'(payload.pop_back());
                end else begin
                    payload.push_front(END_TEXT[0]);
                end
            end
            default: begin
                r = $urandom_range(0, 99);
                if (r < 90) n = $urandom_range(0, 12);
                else if (r < 98) n = $urandom_range(13, 40);
                else n = $urandom_range(256, 300);
                repeat (n) payload.insert(payload.size(), 8'($urandom));
            end
        endcase
    endtask

    // Receiver: draws a stall before each result and then holds ready high
    // until a transaction has been taken.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Ends the run when neither channel has moved a transaction for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        items_sent  = 0;
        gen_closed  = 1'b0;
        no_idle     = 1'b0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.cmd     <= CMD_BYTE;
        in_ch.in_byte <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An empty frame ends on its last header byte.
        payload.delete();
        send_frame(1'b0);
        // First hello of the session is tagged as such.
        for (int i = 0; i < 5; i++) payload.insert(payload.size(), HELLO_TEXT[i]);
        send_frame(1'b0);
        payload.delete();
        for (int i = 0; i < 3; i++) payload.insert(payload.size(), END_TEXT[i]);
        send_frame(1'b0);
        // A closed stream swallows bytes, the unused command does nothing,
        // and a restart reopens the stream.
        send(CMD_CLOSE, 8'h00);
        send(CMD_BYTE, 8'hFF);
        send(CMD_UNUSED, 8'hFF);
        send(CMD_RESTART, 8'h00);

        // Random part: mostly well-formed frames, with restarts so that hello
        // frames are tagged again, and detours dropped into frames.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send(CMD_RESTART, 8'($urandom));
            end else if (r < 12) begin
                side_trip();
            end else begin
                build_payload();
                send_frame($urandom_range(0, 99) < 15);
            end
        end

        // Largest possible length: the frame can never finish, so this goes
        // last and only its first payload bytes are passed through.
        no_idle = 1'b0;
        repeat (4) send(CMD_BYTE, 8'hFF);
        repeat (20) send(CMD_BYTE, 8'($urandom));
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
